FILE: src/tdsb_pkg.sv
package tdsb_pkg;

  // Command codes
  localparam logic [2:0] CMD_PUT     = 3'd0;
  localparam logic [2:0] CMD_NEWLINE = 3'd1;
  localparam logic [2:0] CMD_POS_PUT = 3'd2;
  localparam logic [2:0] CMD_CLR_ROW = 3'd3;
  localparam logic [2:0] CMD_SCROLL  = 3'd4;
  localparam logic [2:0] CMD_CLR_ALL = 3'd5;
  localparam logic [2:0] CMD_UPDATE  = 3'd6;

  // Register indexes (word address bits [3:2])
  localparam logic [1:0] REG_COLUMNS = 2'd0;
  localparam logic [1:0] REG_ROWS    = 2'd1;
  localparam logic [1:0] REG_BLINK   = 2'd2;

  localparam logic [4:0] COLUMNS_RST = 5'd16;
  localparam logic [2:0] ROWS_RST    = 3'd2;
  localparam logic [7:0] BLINK_RST   = 8'd1;

  localparam logic [7:0] SPACE_CODE   = 8'h20;
  localparam logic [7:0] NEWLINE_CODE = 8'h0A;

  // Width of linear cell arithmetic (row * columns + column, up to 111)
  localparam int LIN_W = 8;

  typedef struct packed {
    logic [2:0] command;
    logic [7:0] character;
    logic [7:0] attribute;
    logic [5:0] column;
    logic [1:0] row;
    logic       blink_phase;
  } tdsb_cmd_t;

  typedef struct packed {
    logic [3:0] cell_column;
    logic [1:0] cell_row;
    logic [7:0] cell_char;
    logic       last;
  } tdsb_result_t;

  typedef struct packed {
    logic [7:0] ch;
    logic [7:0] attr;
  } cell_t;

  localparam cell_t BLANK_CELL = '{ch: SPACE_CODE, attr: 8'd0};

  // Store port controls
  typedef struct packed {
    logic wr_en;
    logic clr_all;
    logic clr_range;
  } store_ctl_t;

endpackage

FILE: src/tdsb_cell_store.sv
module tdsb_cell_store #(
  parameter int DEPTH = 64,
  parameter int AW    = 6,
  parameter int CW    = 7
) (
  input  logic                clk,
  input  logic                rst,
  input  tdsb_pkg::store_ctl_t ctl,
  input  logic [AW-1:0]       wr_addr,
  input  tdsb_pkg::cell_t     wr_data,
  input  logic [CW-1:0]       clr_lo,
  input  logic [CW-1:0]       clr_hi,
  input  logic [AW-1:0]       rd_addr,
  output tdsb_pkg::cell_t     rd_data
);
  import tdsb_pkg::*;

  cell_t             mem [DEPTH];
  logic [DEPTH-1:0]  valid;
  logic [DEPTH-1:0]  valid_next;
  cell_t             rd_q;
  logic              rd_valid;

  // Never-written or cleared entries read as blank; a write wins over a clear
  always_comb begin
    valid_next = valid;
    if (ctl.clr_all) begin
      valid_next = '0;
    end
    if (ctl.clr_range) begin
      for (int i = 0; i < DEPTH; i++) begin
        if (CW'(i) >= clr_lo && CW'(i) < clr_hi) begin
          valid_next[i] = 1'b0;
        end
      end
    end
    if (ctl.wr_en) begin
      valid_next[wr_addr] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q     <= mem[rd_addr];
    rd_valid <= valid[rd_addr];
  end

  assign rd_data = rd_valid ? rd_q : BLANK_CELL;

endmodule

FILE: src/text_display_shadow_buffer.sv
// Double-buffered character display controller.
// Command channel: a word on cmd_word is taken at a clock edge with start
// high and busy low. Result channel: each emitted cell appears on result
// for one cycle with strobe high; the receiver must take it then.
// Configuration: APB-style port, registers at 0x0 (columns), 0x4 (rows),
// 0x8 (blink mask); pready is tied high. Write only while busy is low.
//
// Busy per command:
//   puts without scroll, newline, clear row, clear all: busy
//   never rises.
//   scroll (or a cursor put that scrolls): busy from the accept until
//   the last cell has moved, one cell moved per cycle.
//   update: busy until the walk ends, one cell compared per cycle
//   against the live buffer; results trail their cell by up to one emission
//   since the newest one is held back until it is known whether it is last.
//
// Reset: synchronous rst clears the valid bits of both buffers, so every
// cell reads as a blank at once; there is no clearing sweep. Cursor,
// blink phase and registers return to their reset values. There is no
// result back-pressure: strobe words are never stalled.
module text_display_shadow_buffer #(
  parameter int MAX_COLUMNS = 16,
  parameter int MAX_ROWS    = 4
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  tdsb_pkg::tdsb_cmd_t    cmd_word,
  output logic                   strobe,
  output tdsb_pkg::tdsb_result_t result,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [3:0]             paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);
  import tdsb_pkg::*;

  localparam int CELLS = MAX_COLUMNS * MAX_ROWS;
  localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int CW    = $clog2(CELLS + 1);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SCROLL = 3'b010,
    ST_UPDATE = 3'b100
  } state_t;

  state_t state;

  // Registers
  logic [4:0] active_columns;
  logic [2:0] active_rows;
  logic [7:0] blink_bit_mask;

  logic [4:0] cursor_column;
  logic [1:0] cursor_row;
  logic       last_blink_phase;
  logic       phase;

  // Scroll sequencer
  logic [CW-1:0] mv_cnt;
  logic          mv_valid;
  logic [AW-1:0] mv_addr;
  logic          put_after;
  logic [AW-1:0] put_addr;
  cell_t         put_data;

  // Update walk
  logic [CW-1:0] upd_cnt;
  logic [3:0]    upd_col;
  logic [1:0]    upd_row;
  logic          s1_valid;
  logic [AW-1:0] s1_addr;
  logic [3:0]    s1_col;
  logic [1:0]    s1_row;
  logic          hold_valid;
  logic [3:0]    hold_col;
  logic [1:0]    hold_row;
  logic [7:0]    hold_char;

  // Effective geometry, saturated
  logic [4:0]       eff_cols;
  logic [2:0]       eff_rows;
  logic [2:0]       rows_m1;
  logic [LIN_W-1:0] n_cells;
  logic [LIN_W-1:0] n_move;

  always_comb begin
    if (active_columns == 5'd0) begin
      eff_cols = 5'd1;
    end else if (active_columns > 5'(MAX_COLUMNS)) begin
      eff_cols = 5'(MAX_COLUMNS);
    end else begin
      eff_cols = active_columns;
    end
    if (active_rows == 3'd0) begin
      eff_rows = 3'd1;
    end else if (active_rows > 3'(MAX_ROWS)) begin
      eff_rows = 3'(MAX_ROWS);
    end else begin
      eff_rows = active_rows;
    end
    rows_m1 = eff_rows - 3'd1;
    n_cells = LIN_W'(eff_rows) * LIN_W'(eff_cols);
    n_move  = LIN_W'(rows_m1) * LIN_W'(eff_cols);
  end

  logic accept;
  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;

  // Cursor put target
  logic [2:0]       row_clamp;
  logic [2:0]       row_inc;
  logic             wrap;
  logic             need_scroll;
  logic [2:0]       put_row;
  logic [4:0]       put_col;
  logic [LIN_W-1:0] put_lin;
  logic             put_char_ok;

  always_comb begin
    row_clamp   = ({1'b0, cursor_row} >= eff_rows) ? rows_m1 : {1'b0, cursor_row};
    row_inc     = row_clamp + 3'd1;
    wrap        = (cursor_column >= eff_cols);
    need_scroll = wrap && (row_inc >= eff_rows);
    if (!wrap) begin
      put_row = row_clamp;
    end else if (need_scroll) begin
      put_row = rows_m1;
    end else begin
      put_row = row_inc;
    end
    put_col     = wrap ? 5'd0 : cursor_column;
    put_lin     = LIN_W'(put_row) * LIN_W'(eff_cols) + LIN_W'(put_col);
    put_char_ok = (cmd_word.character != 8'd0) && (cmd_word.character != NEWLINE_CODE);
  end

  // Positioned put and clear row
  logic [LIN_W-1:0] pos_lin;
  logic             pos_ok;
  logic [LIN_W-1:0] row_lo;
  logic             row_ok;

  always_comb begin
    pos_lin = LIN_W'(cmd_word.row) * LIN_W'(eff_cols) + LIN_W'(cmd_word.column);
    pos_ok  = (cmd_word.character != 8'd0) && (pos_lin < n_cells);
    row_lo  = LIN_W'(cmd_word.row) * LIN_W'(eff_cols);
    row_ok  = ({1'b0, cmd_word.row} < eff_rows);
  end

  logic scroll_done;
  logic upd_done;
  assign scroll_done = (state == ST_SCROLL) && (LIN_W'(mv_cnt) >= n_move) && !mv_valid;
  assign upd_done    = (state == ST_UPDATE) && (LIN_W'(upd_cnt) >= n_cells) && !s1_valid;

  // Buffers
  store_ctl_t    p_ctl;
  logic [AW-1:0] p_waddr;
  cell_t         p_wdata;
  logic [CW-1:0] p_clr_lo;
  logic [CW-1:0] p_clr_hi;
  logic [AW-1:0] p_raddr;
  cell_t         p_rdata;

  store_ctl_t    l_ctl;
  cell_t         l_rdata;

  // Compare stage
  logic  differs;
  logic  emit;
  logic  blink_on;
  logic  [7:0] shown_char;

  always_comb begin
    differs    = (p_rdata != l_rdata);
    blink_on   = ((p_rdata.attr & blink_bit_mask) != 8'd0);
    emit       = differs ||
                 ((last_blink_phase != phase) && ((l_rdata.attr & blink_bit_mask) != 8'd0));
    // when not differing, pending equals live, so pending fields serve for both
    shown_char = (blink_on && !phase) ? SPACE_CODE : p_rdata.ch;
  end

  // Pending store port selection
  always_comb begin
    p_ctl    = '0;
    p_waddr  = mv_addr;
    p_wdata  = p_rdata;
    p_clr_lo = CW'(n_move);
    p_clr_hi = CW'(n_cells);
    p_raddr  = (state == ST_SCROLL) ? AW'(LIN_W'(mv_cnt) + LIN_W'(eff_cols)) : AW'(upd_cnt);
    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (cmd_word.command)
            CMD_PUT: begin
              if (put_char_ok && !need_scroll) begin
                p_ctl.wr_en = 1'b1;
                p_waddr     = AW'(put_lin);
                p_wdata     = '{ch: cmd_word.character, attr: cmd_word.attribute};
              end
            end
            CMD_POS_PUT: begin
              if (pos_ok) begin
                p_ctl.wr_en = 1'b1;
                p_waddr     = AW'(pos_lin);
                p_wdata     = '{ch: cmd_word.character, attr: cmd_word.attribute};
              end
            end
            CMD_CLR_ROW: begin
              p_ctl.clr_range = row_ok;
              p_clr_lo        = CW'(row_lo);
              p_clr_hi        = CW'(row_lo + LIN_W'(eff_cols));
            end
            CMD_CLR_ALL: begin
              p_ctl.clr_all = 1'b1;
            end
            default: ;
          endcase
        end
      end
      ST_SCROLL: begin
        if (mv_valid) begin
          p_ctl.wr_en = 1'b1;
        end
        if (scroll_done) begin
          // bottom row blanks; a deferred cursor put lands on top of it
          p_ctl.clr_range = 1'b1;
          if (put_after) begin
            p_ctl.wr_en = 1'b1;
            p_waddr     = put_addr;
            p_wdata     = put_data;
          end
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    l_ctl       = '0;
    l_ctl.wr_en = (state == ST_UPDATE) && s1_valid && differs;
  end

  tdsb_cell_store #(.DEPTH(CELLS), .AW(AW), .CW(CW)) u_pending (
    .clk     (clk),
    .rst     (rst),
    .ctl     (p_ctl),
    .wr_addr (p_waddr),
    .wr_data (p_wdata),
    .clr_lo  (p_clr_lo),
    .clr_hi  (p_clr_hi),
    .rd_addr (p_raddr),
    .rd_data (p_rdata)
  );

  tdsb_cell_store #(.DEPTH(CELLS), .AW(AW), .CW(CW)) u_live (
    .clk     (clk),
    .rst     (rst),
    .ctl     (l_ctl),
    .wr_addr (s1_addr),
    .wr_data (p_rdata),
    .clr_lo  ('0),
    .clr_hi  ('0),
    .rd_addr (AW'(upd_cnt)),
    .rd_data (l_rdata)
  );

  // Config port
  logic cfg_wr;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;

  always_comb begin
    case (paddr[3:2])
      REG_COLUMNS: prdata = {27'd0, active_columns};
      REG_ROWS:    prdata = {29'd0, active_rows};
      REG_BLINK:   prdata = {24'd0, blink_bit_mask};
      default:     prdata = 32'd0;
    endcase
  end

  // Result strobe: a held word goes out on the next emission or at the end
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= hold_valid && (((state == ST_UPDATE) && s1_valid && emit) || upd_done);
    end
  end

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      active_columns   <= COLUMNS_RST;
      active_rows      <= ROWS_RST;
      blink_bit_mask   <= BLINK_RST;
      cursor_column    <= 5'd0;
      cursor_row       <= 2'd0;
      last_blink_phase <= 1'b0;
      mv_valid         <= 1'b0;
      s1_valid         <= 1'b0;
      hold_valid       <= 1'b0;
      put_after        <= 1'b0;
      mv_cnt           <= '0;
      upd_cnt          <= '0;
    end else begin
      if (cfg_wr) begin
        case (paddr[3:2])
          REG_COLUMNS: active_columns <= pwdata[4:0];
          REG_ROWS:    active_rows    <= pwdata[2:0];
          REG_BLINK:   blink_bit_mask <= pwdata[7:0];
          default: ;
        endcase
      end

      case (state)
        ST_IDLE: begin
          if (accept) begin
            case (cmd_word.command)
              CMD_PUT: begin
                if (cmd_word.character == NEWLINE_CODE) begin
                  cursor_column <= eff_cols;
                end else if (cmd_word.character != 8'd0) begin
                  cursor_row    <= put_row[1:0];
                  cursor_column <= put_col + 5'd1;
                  if (need_scroll) begin
                    put_after <= 1'b1;
                    put_addr  <= AW'(put_lin);
                    put_data  <= '{ch: cmd_word.character, attr: cmd_word.attribute};
                    mv_cnt    <= '0;
                    mv_valid  <= 1'b0;
                    state     <= ST_SCROLL;
                  end
                end
              end
              CMD_NEWLINE: begin
                cursor_column <= eff_cols;
              end
              CMD_SCROLL: begin
                put_after <= 1'b0;
                mv_cnt    <= '0;
                mv_valid  <= 1'b0;
                state     <= ST_SCROLL;
              end
              CMD_UPDATE: begin
                upd_cnt    <= '0;
                upd_col    <= 4'd0;
                upd_row    <= 2'd0;
                phase      <= cmd_word.blink_phase;
                s1_valid   <= 1'b0;
                hold_valid <= 1'b0;
                state      <= ST_UPDATE;
              end
              default: ;
            endcase
          end
        end

        ST_SCROLL: begin
          // read cell k+cols now, write it to cell k next cycle
          if (LIN_W'(mv_cnt) < n_move) begin
            mv_valid <= 1'b1;
            mv_addr  <= AW'(mv_cnt);
            mv_cnt   <= mv_cnt + CW'(1);
          end else begin
            mv_valid <= 1'b0;
            if (!mv_valid) begin
              state <= ST_IDLE;
            end
          end
        end

        ST_UPDATE: begin
          if (LIN_W'(upd_cnt) < n_cells) begin
            s1_valid <= 1'b1;
            s1_addr  <= AW'(upd_cnt);
            s1_col   <= upd_col;
            s1_row   <= upd_row;
            upd_cnt  <= upd_cnt + CW'(1);
            if ({1'b0, upd_col} == eff_cols - 5'd1) begin
              upd_col <= 4'd0;
              upd_row <= upd_row + 2'd1;
            end else begin
              upd_col <= upd_col + 4'd1;
            end
          end else begin
            s1_valid <= 1'b0;
          end

          // newest emission is held until the next one (or the end) shows up
          if (s1_valid && emit) begin
            if (hold_valid) begin
              result <= '{cell_column: hold_col, cell_row: hold_row,
                          cell_char: hold_char, last: 1'b0};
            end
            hold_valid <= 1'b1;
            hold_col   <= s1_col;
            hold_row   <= s1_row;
            hold_char  <= shown_char;
          end

          if (upd_done) begin
            if (hold_valid) begin
              result <= '{cell_column: hold_col, cell_row: hold_row,
                          cell_char: hold_char, last: 1'b1};
            end
            hold_valid       <= 1'b0;
            last_blink_phase <= phase;
            state            <= ST_IDLE;
          end
        end

        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

FILE: src/tdsb_checker.sv
module tdsb_checker (
  input logic                   clk,
  input logic                   rst,
  input logic                   start,
  input logic                   busy,
  input logic                   strobe,
  input tdsb_pkg::tdsb_result_t result
);
  import tdsb_pkg::*;

  // no stray word right out of reset
  a_rst_quiet: assert property (@(posedge clk) rst |=> !strobe)
    else $error("strobe after reset");

  // a word that is not the final one comes while the update walk runs
  a_mid_busy: assert property (@(posedge clk) disable iff (rst)
    strobe && !result.last |-> busy)
    else $error("non-final word outside an update");

  // final word closes the burst
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    strobe && result.last |=> !strobe)
    else $error("word after final word");

  // a newly taken command produces nothing on the next cycle
  a_start_gap: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> !strobe)
    else $error("word right after command accept");

endmodule

bind text_display_shadow_buffer tdsb_checker u_tdsb_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .strobe (strobe),
  .result (result)
);
